// ===== rtl/core/dpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

   typedef enum logic [1:0] {
      PHASE_PREDROP = 2'd0,
      PHASE_DESCENT = 2'd1,
      PHASE_LANDED  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CSR_RELEASE_ACCEL_MAX  = 3'd0,
      CSR_RELEASE_DROP_MIN   = 3'd1,
      CSR_RELEASE_COUNT      = 3'd2,
      CSR_LANDING_ACCEL_MIN  = 3'd3,
      CSR_LANDING_ALT_MAX    = 3'd4,
      CSR_LANDING_CHANGE_MAX = 3'd5,
      CSR_LANDING_COUNT      = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int ACCEL_W     = 16;
   localparam int ALT_W       = 24;
   localparam int THRESH_W    = 15;
   localparam int LIMIT_W     = 2 * THRESH_W;
   localparam int SQUARE_W    = 2 * ACCEL_W - 1;
   localparam int MAG_W       = 2 * ACCEL_W;
   localparam int DIST_W      = 23;
   localparam int STREAK_W    = 8;

   localparam logic [THRESH_W-1:0] RST_RELEASE_ACCEL_MAX  = 15'd300;
   localparam logic [DIST_W-1:0]   RST_RELEASE_DROP_MIN   = 23'd50;
   localparam logic [STREAK_W-1:0] RST_RELEASE_COUNT      = 8'd5;
   localparam logic [THRESH_W-1:0] RST_LANDING_ACCEL_MIN  = 15'd1100;
   localparam logic [ALT_W-1:0]    RST_LANDING_ALT_MAX    = 24'd1000;
   localparam logic [DIST_W-1:0]   RST_LANDING_CHANGE_MAX = 23'd20;
   localparam logic [STREAK_W-1:0] RST_LANDING_COUNT      = 8'd20;

   localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

   typedef struct packed {
      logic [LIMIT_W-1:0]     release_limit;  // release_accel_max squared
      logic [DIST_W-1:0]      release_drop_min;
      logic [STREAK_W-1:0]    release_count;
      logic [LIMIT_W-1:0]     landing_limit;  // landing_accel_min squared
      logic signed [ALT_W-1:0] landing_alt_max;
      logic [DIST_W-1:0]      landing_change_max;
      logic [STREAK_W-1:0]    landing_count;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/dpd_config.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpd_config
   import dpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   logic [THRESH_W-1:0] rel_accel_ff, rel_accel_in;
   logic [DIST_W-1:0]   rel_drop_ff, rel_drop_in;
   logic [STREAK_W-1:0] rel_count_ff, rel_count_in;
   logic [THRESH_W-1:0] land_accel_ff, land_accel_in;
   logic [ALT_W-1:0]    land_alt_ff, land_alt_in;
   logic [DIST_W-1:0]   land_change_ff, land_change_in;
   logic [STREAK_W-1:0] land_count_ff, land_count_in;
   logic [LIMIT_W-1:0]  rel_limit_ff, rel_limit_in;
   logic [LIMIT_W-1:0]  land_limit_ff, land_limit_in;

   always_comb begin
      rel_accel_in   = rel_accel_ff;
      rel_drop_in    = rel_drop_ff;
      rel_count_in   = rel_count_ff;
      land_accel_in  = land_accel_ff;
      land_alt_in    = land_alt_ff;
      land_change_in = land_change_ff;
      land_count_in  = land_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RELEASE_ACCEL_MAX:  rel_accel_in   = csr_wdata[THRESH_W-1:0];
            CSR_RELEASE_DROP_MIN:   rel_drop_in    = csr_wdata[DIST_W-1:0];
            CSR_RELEASE_COUNT:      rel_count_in   = csr_wdata[STREAK_W-1:0];
            CSR_LANDING_ACCEL_MIN:  land_accel_in  = csr_wdata[THRESH_W-1:0];
            CSR_LANDING_ALT_MAX:    land_alt_in    = csr_wdata[ALT_W-1:0];
            CSR_LANDING_CHANGE_MAX: land_change_in = csr_wdata[DIST_W-1:0];
            CSR_LANDING_COUNT:      land_count_in  = csr_wdata[STREAK_W-1:0];
            default: ;
         endcase
      end
      // squared thresholds are registered from the raw registers and follow them in the next cycle
      rel_limit_in  = LIMIT_W'(rel_accel_ff) * LIMIT_W'(rel_accel_ff);
      land_limit_in = LIMIT_W'(land_accel_ff) * LIMIT_W'(land_accel_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_accel_ff   <= RST_RELEASE_ACCEL_MAX;
         rel_drop_ff    <= RST_RELEASE_DROP_MIN;
         rel_count_ff   <= RST_RELEASE_COUNT;
         land_accel_ff  <= RST_LANDING_ACCEL_MIN;
         land_alt_ff    <= RST_LANDING_ALT_MAX;
         land_change_ff <= RST_LANDING_CHANGE_MAX;
         land_count_ff  <= RST_LANDING_COUNT;
         rel_limit_ff   <= LIMIT_W'(RST_RELEASE_ACCEL_MAX) * LIMIT_W'(RST_RELEASE_ACCEL_MAX);
         land_limit_ff  <= LIMIT_W'(RST_LANDING_ACCEL_MIN) * LIMIT_W'(RST_LANDING_ACCEL_MIN);
      end else begin
         rel_accel_ff   <= rel_accel_in;
         rel_drop_ff    <= rel_drop_in;
         rel_count_ff   <= rel_count_in;
         land_accel_ff  <= land_accel_in;
         land_alt_ff    <= land_alt_in;
         land_change_ff <= land_change_in;
         land_count_ff  <= land_count_in;
         rel_limit_ff   <= rel_limit_in;
         land_limit_ff  <= land_limit_in;
      end
   end

   assign cfg.release_limit      = rel_limit_ff;
   assign cfg.release_drop_min   = rel_drop_ff;
   assign cfg.release_count      = rel_count_ff;
   assign cfg.landing_limit      = land_limit_ff;
   assign cfg.landing_alt_max    = $signed(land_alt_ff);
   assign cfg.landing_change_max = land_change_ff;
   assign cfg.landing_count      = land_count_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dpd_square.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input register, then a register holding the three squared axes.
module dpd_square
   import dpd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [ACCEL_W-1:0] in_accel_x,
   input  wire logic signed [ACCEL_W-1:0] in_accel_y,
   input  wire logic signed [ACCEL_W-1:0] in_accel_z,
   input  wire logic signed [ALT_W-1:0]   in_altitude,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [SQUARE_W-1:0]           out_sq_x,
   output logic [SQUARE_W-1:0]           out_sq_y,
   output logic [SQUARE_W-1:0]           out_sq_z,
   output logic signed [ALT_W-1:0]       out_altitude
);

   logic                      v1_ff, v1_in;
   logic signed [ACCEL_W-1:0] ax_ff, ay_ff, az_ff;
   logic signed [ALT_W-1:0]   alt1_ff;
   logic                      v2_ff, v2_in;
   logic [SQUARE_W-1:0]       sqx_ff, sqy_ff, sqz_ff;
   logic signed [ALT_W-1:0]   alt2_ff;
   logic signed [MAG_W-1:0]   prod_x, prod_y, prod_z;
   logic                      ready1, ready2;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   assign prod_x = ax_ff * ax_ff;
   assign prod_y = ay_ff * ay_ff;
   assign prod_z = az_ff * az_ff;

   always_comb begin
      v1_in = v1_ff;
      if (ready1) begin
         v1_in = in_valid;
      end
      v2_in = v2_ff;
      if (ready2) begin
         v2_in = v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         ax_ff   <= in_accel_x;
         ay_ff   <= in_accel_y;
         az_ff   <= in_accel_z;
         alt1_ff <= in_altitude;
      end
      if (ready2 && v1_ff) begin
         sqx_ff  <= $unsigned(prod_x[SQUARE_W-1:0]);
         sqy_ff  <= $unsigned(prod_y[SQUARE_W-1:0]);
         sqz_ff  <= $unsigned(prod_z[SQUARE_W-1:0]);
         alt2_ff <= alt1_ff;
      end
   end

   assign out_valid    = v2_ff;
   assign out_sq_x     = sqx_ff;
   assign out_sq_y     = sqy_ff;
   assign out_sq_z     = sqz_ff;
   assign out_altitude = alt2_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dpd_track.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Phase and streak tracking; the result register sits here.
module dpd_track
   import dpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SQUARE_W-1:0]    in_sq_x,
   input  wire logic [SQUARE_W-1:0]    in_sq_y,
   input  wire logic [SQUARE_W-1:0]    in_sq_z,
   input  wire logic signed [ALT_W-1:0] in_altitude,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [1:0]                  out_phase,
   output logic                        out_release_now,
   output logic                        out_landed_now,
   output logic [STREAK_W-1:0]         out_release_streak,
   output logic [STREAK_W-1:0]         out_landing_streak
);

   phase_type               phase_ff, phase_in;
   logic                    primed_ff, primed_in;
   logic signed [ALT_W-1:0] last_alt_ff, last_alt_in;
   logic [STREAK_W-1:0]     rel_cnt_ff, rel_cnt_in;
   logic [STREAK_W-1:0]     land_cnt_ff, land_cnt_in;
   logic                    valid_ff, valid_in;
   logic                    rel_now_ff, rel_now_in;
   logic                    land_now_ff, land_now_in;

   logic                    take;
   logic [MAG_W-1:0]        mag2;
   logic signed [ALT_W:0]   drop;
   logic [ALT_W:0]          change;
   logic                    rel_hit, land_hit;
   logic [STREAK_W-1:0]     rel_bump, land_bump;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign mag2 = MAG_W'(in_sq_x) + MAG_W'(in_sq_y) + MAG_W'(in_sq_z);
   assign drop = (ALT_W+1)'(last_alt_ff) - (ALT_W+1)'(in_altitude);
   assign change = drop[ALT_W] ? $unsigned(-drop) : $unsigned(drop);

   assign rel_hit = (mag2 < MAG_W'(cfg.release_limit))
                  && (drop > $signed({2'b00, cfg.release_drop_min}));
   assign land_hit = (mag2 > MAG_W'(cfg.landing_limit))
                   && (in_altitude < cfg.landing_alt_max)
                   && (change < {2'b00, cfg.landing_change_max});

   assign rel_bump  = (rel_cnt_ff == STREAK_MAX) ? STREAK_MAX : rel_cnt_ff + 1'b1;
   assign land_bump = (land_cnt_ff == STREAK_MAX) ? STREAK_MAX : land_cnt_ff + 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      primed_in   = primed_ff;
      last_alt_in = last_alt_ff;
      rel_cnt_in  = rel_cnt_ff;
      land_cnt_in = land_cnt_ff;
      rel_now_in  = rel_now_ff;
      land_now_in = land_now_ff;
      valid_in    = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (take) begin
         primed_in   = 1'b1;
         last_alt_in = in_altitude;
         rel_now_in  = 1'b0;
         land_now_in = 1'b0;
         if (primed_ff) begin
            unique case (phase_ff)
               PHASE_PREDROP: begin
                  rel_cnt_in = rel_hit ? rel_bump : '0;
                  if (rel_cnt_in > cfg.release_count) begin
                     phase_in   = PHASE_DESCENT;
                     rel_now_in = 1'b1;
                  end
               end
               PHASE_DESCENT: begin
                  land_cnt_in = land_hit ? land_bump : '0;
                  if (land_cnt_in >= cfg.landing_count) begin
                     phase_in    = PHASE_LANDED;
                     land_now_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_PREDROP;
         primed_ff   <= 1'b0;
         last_alt_ff <= '0;
         rel_cnt_ff  <= '0;
         land_cnt_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         primed_ff   <= primed_in;
         last_alt_ff <= last_alt_in;
         rel_cnt_ff  <= rel_cnt_in;
         land_cnt_ff <= land_cnt_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_now_ff  <= rel_now_in;
      land_now_ff <= land_now_in;
   end

   // phase and streak registers double as the result payload
   assign out_valid          = valid_ff;
   assign out_phase          = phase_ff;
   assign out_release_now    = rel_now_ff;
   assign out_landed_now     = land_now_ff;
   assign out_release_streak = rel_cnt_ff;
   assign out_landing_streak = land_cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/core/descent_phase_detector.sv =====
// Descent phase detector.
// req_ carries one sensor sample per transaction (three acceleration axes and
// altitude); rsp_ returns exactly one result per sample: the flight phase,
// the transition flags of that sample and both persistence streaks.
// csr_ writes one of seven threshold registers at any edge with csr_we high;
// write only while no sample is in flight.
// A sample accepted at an edge loads the input register, then the square
// register, then the result register, which drives rsp_.
// Throughput: one sample per cycle; the three pipeline registers each have
// their own valid bit, so the block keeps taking samples while a finished
// result waits for rsp_tready, until every stage is full.
// Reset (synchronous) empties the pipeline, restores the threshold defaults
// and returns to predrop; the first sample after reset only records altitude.
// A stalled receiver holds rsp_tdata steady and back-pressures req_tready.
`timescale 1ns / 1ps
`default_nettype none

module descent_phase_detector
   import dpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [71:48] altitude
   input  wire logic [71:0]            req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [1:0] phase, [2] release_now, [3] landed_now, [11:4] release_streak,
   // [19:12] landing_streak, [23:20] zero
   output logic [23:0]                 rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                 cfg;
   logic                    sq_valid, sq_ready;
   logic [SQUARE_W-1:0]     sq_x, sq_y, sq_z;
   logic signed [ALT_W-1:0] sq_alt;
   logic [1:0]              phase;
   logic                    release_now, landed_now;
   logic [STREAK_W-1:0]     release_streak, landing_streak;

   dpd_config u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dpd_square u_square (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_accel_x   ($signed(req_tdata[15:0])),
      .in_accel_y   ($signed(req_tdata[31:16])),
      .in_accel_z   ($signed(req_tdata[47:32])),
      .in_altitude  ($signed(req_tdata[71:48])),
      .out_valid    (sq_valid),
      .out_ready    (sq_ready),
      .out_sq_x     (sq_x),
      .out_sq_y     (sq_y),
      .out_sq_z     (sq_z),
      .out_altitude (sq_alt)
   );

   dpd_track u_track (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .in_valid           (sq_valid),
      .in_ready           (sq_ready),
      .in_sq_x            (sq_x),
      .in_sq_y            (sq_y),
      .in_sq_z            (sq_z),
      .in_altitude        (sq_alt),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_phase          (phase),
      .out_release_now    (release_now),
      .out_landed_now     (landed_now),
      .out_release_streak (release_streak),
      .out_landing_streak (landing_streak)
   );

   assign rsp_tdata = {4'b0000, landing_streak, release_streak, landed_now, release_now, phase};

endmodule

`default_nettype wire

// ===== verif/dpd_phase_checker.sv =====
`timescale 1ns / 1ps

module dpd_phase_checker
   import dpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [71:0]            req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [23:0]            rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          open_reports,
   output int                          mismatches
);

   // highest bits first, same order as the rsp_tdata concatenation
   typedef struct packed {
      logic [STREAK_W-1:0] landing_streak;
      logic [STREAK_W-1:0] release_streak;
      logic                landed_now;
      logic                release_now;
      phase_type           phase;
   } phase_report_type;

   // thresholds as last written
   logic [THRESH_W-1:0]     release_accel_max;
   logic [DIST_W-1:0]       release_drop_min;
   logic [STREAK_W-1:0]     release_count;
   logic [THRESH_W-1:0]     landing_accel_min;
   logic signed [ALT_W-1:0] landing_alt_max;
   logic [DIST_W-1:0]       landing_change_max;
   logic [STREAK_W-1:0]     landing_count;

   // tracked flight state
   phase_type               flight;
   logic signed [ALT_W-1:0] prior_alt;
   logic                    armed;
   logic [STREAK_W-1:0]     release_run;
   logic [STREAK_W-1:0]     landing_run;

   phase_report_type expected_reports[$];
   phase_report_type want_rep;
   phase_report_type got_rep;

   initial mismatches = 0;

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic track_sample(input logic [71:0] word);
      logic signed [ACCEL_W-1:0] ax;
      logic signed [ACCEL_W-1:0] ay;
      logic signed [ACCEL_W-1:0] az;
      logic signed [ALT_W-1:0]   alt;
      longint                    mag2;
      longint                    drop;
      longint                    chg;
      phase_report_type          rep;
      ax = word[15:0];
      ay = word[31:16];
      az = word[47:32];
      alt = word[71:48];
      mag2 = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
           + longint'(az) * longint'(az);
      drop = longint'(prior_alt) - longint'(alt);
      chg = (drop < 0) ? -drop : drop;
      rep = '0;
      if (armed) begin
         case (flight)
            PHASE_PREDROP: begin
               if (mag2 < longint'(release_accel_max) * longint'(release_accel_max)
                   && drop > longint'(release_drop_min))
                  release_run = (release_run == STREAK_MAX) ? STREAK_MAX : release_run + 1'b1;
               else
                  release_run = '0;
               if (release_run > release_count) begin
                  flight = PHASE_DESCENT;
                  rep.release_now = 1'b1;
               end
            end
            PHASE_DESCENT: begin
               if (mag2 > longint'(landing_accel_min) * longint'(landing_accel_min)
                   && alt < landing_alt_max && chg < longint'(landing_change_max))
                  landing_run = (landing_run == STREAK_MAX) ? STREAK_MAX : landing_run + 1'b1;
               else
                  landing_run = '0;
               if (landing_run >= landing_count) begin
                  flight = PHASE_LANDED;
                  rep.landed_now = 1'b1;
               end
            end
            default: ;
         endcase
      end
      armed = 1'b1;
      prior_alt = alt;
      rep.phase = flight;
      rep.release_streak = release_run;
      rep.landing_streak = landing_run;
      expected_reports.push_back(rep);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         release_accel_max = RST_RELEASE_ACCEL_MAX;
         release_drop_min = RST_RELEASE_DROP_MIN;
         release_count = RST_RELEASE_COUNT;
         landing_accel_min = RST_LANDING_ACCEL_MIN;
         landing_alt_max = RST_LANDING_ALT_MAX;
         landing_change_max = RST_LANDING_CHANGE_MAX;
         landing_count = RST_LANDING_COUNT;
         flight = PHASE_PREDROP;
         prior_alt = '0;
         armed = 1'b0;
         release_run = '0;
         landing_run = '0;
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RELEASE_ACCEL_MAX:  release_accel_max = csr_wdata[THRESH_W-1:0];
               CSR_RELEASE_DROP_MIN:   release_drop_min = csr_wdata[DIST_W-1:0];
               CSR_RELEASE_COUNT:      release_count = csr_wdata[STREAK_W-1:0];
               CSR_LANDING_ACCEL_MIN:  landing_accel_min = csr_wdata[THRESH_W-1:0];
               CSR_LANDING_ALT_MAX:    landing_alt_max = csr_wdata;
               CSR_LANDING_CHANGE_MAX: landing_change_max = csr_wdata[DIST_W-1:0];
               CSR_LANDING_COUNT:      landing_count = csr_wdata[STREAK_W-1:0];
               default: ;
            endcase
         end
         // results leave before the sample of this edge could produce one
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected result transaction: %h", rsp_tdata);
               mismatches++;
            end else begin
               want_rep = expected_reports.pop_front();
               got_rep = rsp_tdata[19:0];
               check_field("phase", want_rep.phase, got_rep.phase);
               check_field("release_now", want_rep.release_now, got_rep.release_now);
               check_field("landed_now", want_rep.landed_now, got_rep.landed_now);
               check_field("release_streak", want_rep.release_streak, got_rep.release_streak);
               check_field("landing_streak", want_rep.landing_streak, got_rep.landing_streak);
            end
         end
         if (req_tvalid && req_tready)
            track_sample(req_tdata);
      end
      open_reports <= expected_reports.size();
   end

endmodule

// ===== verif/tb_descent_phase_detector.sv =====
`timescale 1ns / 1ps

module tb_descent_phase_detector;
   import dpd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ALT_LO = -8388608;
   localparam int ALT_HI = 8388607;

   // copy of the thresholds, used only to shape the samples
   typedef struct {
      int release_accel_max;
      int release_drop_min;
      int landing_accel_min;
      int landing_alt_max;
      int landing_change_max;
   } limits_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [71:0]            req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [23:0]            rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int         open_reports;
   int         mismatches;
   int         cycle_count = 0;
   bit         calm = 1'b0;
   int         last_alt = 0;
   limits_type lim = '{300, 50, 1100, 1000, 20};

   descent_phase_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dpd_phase_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .open_reports (open_reports),
      .mismatches   (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: ready in random bursts, steady once calm
   initial begin
      forever begin
         if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   task automatic put_reg(input csr_index_type idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 24'(val);
      @(posedge clock);
   endtask

   task automatic program_thresholds(input int ra, input int rd, input int rc, input int la,
                                     input int lalt, input int lcm, input int lc);
      put_reg(CSR_RELEASE_ACCEL_MAX, ra);
      put_reg(CSR_RELEASE_DROP_MIN, rd);
      put_reg(CSR_RELEASE_COUNT, rc);
      put_reg(CSR_LANDING_ACCEL_MIN, la);
      put_reg(CSR_LANDING_ALT_MAX, lalt);
      put_reg(CSR_LANDING_CHANGE_MAX, lcm);
      put_reg(CSR_LANDING_COUNT, lc);
      csr_we <= 1'b0;
      lim = '{ra, rd, la, lalt, lcm};
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (open_reports != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic send_sample(input int ax, input int ay, input int az, input int alt);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {24'(alt), 16'(az), 16'(ay), 16'(ax)};
      do
         @(posedge clock);
      while (!req_tready);
      last_alt = alt;
   endtask

   function automatic int edge_or_random(input int bits);
      int r;
      r = $urandom_range(0, 3);
      if (r == 0)
         return -(1 << (bits - 1));
      else if (r == 1)
         return (1 << (bits - 1)) - 1;
      return int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
   endfunction

   function automatic int clamp_alt(input int alt);
      if (alt < ALT_LO)
         return ALT_LO;
      if (alt > ALT_HI)
         return ALT_HI;
      return alt;
   endfunction

   task automatic noise_sample();
      send_sample(edge_or_random(16), edge_or_random(16), edge_or_random(16),
                  edge_or_random(24));
   endtask

   // free fall: low magnitude, altitude drops by more than the minimum unless that would go below ALT_LO
   task automatic release_sample();
      int     h;
      int     alt;
      longint target;
      h = lim.release_accel_max / 2;
      target = longint'(last_alt) - lim.release_drop_min - 1 - $urandom_range(0, 300);
      if (target < ALT_LO)
         alt = ALT_HI - int'($urandom_range(0, 1000));
      else
         alt = int'(target);
      send_sample(int'($urandom_range(0, 2 * h)) - h, int'($urandom_range(0, 2 * h)) - h,
                  int'($urandom_range(0, 2 * h)) - h, alt);
   endtask

   // impact or rest: high magnitude, low and steady altitude
   task automatic landing_sample();
      int ax;
      int w;
      int alt;
      if (lim.landing_accel_min < 32767) begin
         ax = $urandom_range(lim.landing_accel_min + 1, 32767);
         if ($urandom_range(0, 1))
            ax = -ax;
      end else begin
         ax = -32768;
      end
      w = lim.landing_change_max - 1;
      if (w > 500)
         w = 500;
      if (w < 0)
         w = 0;
      alt = last_alt + int'($urandom_range(0, 2 * w)) - w;
      if (alt >= lim.landing_alt_max)
         alt = lim.landing_alt_max - 1 - int'($urandom_range(0, 100));
      send_sample(ax, int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                  clamp_alt(alt));
   endtask

   task automatic mixed_traffic(input int count);
      int sent;
      int kind;
      int run;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind < 2)
            run = 1;
         else if (kind < 6)
            run = $urandom_range(1, 12);
         else
            run = $urandom_range(1, 40);
         if (run > count - sent)
            run = count - sent;
         repeat (run) begin
            if (kind < 2)
               noise_sample();
            else if (kind < 6)
               release_sample();
            else
               landing_sample();
         end
         sent += run;
      end
   endtask

   initial begin
      int ra;
      int rd;
      int rc;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_RELEASE_ACCEL_MAX;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: priming, extremes, and the release boundaries
      send_sample(-32768, 32767, 0, ALT_HI);
      send_sample(0, 0, 0, ALT_LO);
      send_sample(32767, -32768, -32768, ALT_HI);
      send_sample(300, 0, 0, ALT_HI - 100);       // magnitude equal to limit
      send_sample(299, 0, 0, ALT_HI - 200);
      send_sample(0, -173, -173, ALT_HI - 250);   // drop equal to minimum
      send_sample(0, 0, -299, ALT_HI - 301);
      send_sample(1, 1, 1, ALT_HI - 400);
      send_sample(-1, -2, -3, ALT_HI - 500);
      send_sample(100, 100, 100, ALT_HI - 600);
      send_sample(-100, 100, -100, ALT_HI - 700); // streak equals count, no release
      send_sample(0, 0, 0, ALT_HI - 700);
      send_sample(32767, 32767, 32767, ALT_LO);
      send_sample(-32768, -32768, -32768, 0);
      send_sample(-1, -1, -1, -1);
      send_sample(21845, -21846, 21845, 5592405);
      send_sample(0, 0, 0, 0);
      drain_results();

      // release never possible: streak runs into saturation
      program_thresholds(32767, 0, 255, 1100, 1000, 20, 20);
      send_sample(0, 0, 0, ALT_HI - 10);
      repeat (270) release_sample();
      mixed_traffic(60);
      drain_results();

      // largest drop minimum, alternating full-scale altitude
      program_thresholds(32767, 8388607, 254, 0, 8388607, 8388607, 255);
      send_sample(5, -5, 5, 0);
      send_sample(5, -5, 5, -8388607);
      send_sample(5, -5, 5, 0);
      send_sample(5, -5, 5, ALT_LO);
      for (int i = 0; i < 40; i++) begin
         if (i % 8 == 7)
            noise_sample();
         else
            send_sample(int'($urandom_range(0, 64)) - 32, int'($urandom_range(0, 64)) - 32,
                        int'($urandom_range(0, 64)) - 32, (i % 2) ? ALT_LO : ALT_HI);
      end
      drain_results();

      // a clean free-fall run enters descent
      ra = $urandom_range(200, 32767);
      rd = $urandom_range(0, 2000);
      rc = $urandom_range(0, 4);
      program_thresholds(ra, rd, rc, 0, ALT_HI, 8388607, 255);
      send_sample(0, 0, 0, ALT_HI - 10);
      repeat (12) release_sample();
      mixed_traffic(70);
      drain_results();

      program_thresholds(ra, rd, rc, $urandom_range(500, 3000), $urandom_range(0, 100000),
                         $urandom_range(1, 100), 255);
      mixed_traffic(100);
      drain_results();

      // zero landing count: next descent sample lands regardless
      calm = 1'b1;
      program_thresholds(0, 0, 0, 32767, ALT_LO, 0, 0);
      mixed_traffic(80);
      drain_results();

      if (mismatches == 0 && open_reports == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
